// ----- hw/rtl/dll_pkg.sv -----
// Package for the doubly linked list engine.
// Command and status codes, item field widths and the node write-enable group.
// No dependencies.
package dll_pkg;

  localparam int unsigned ACTION_W = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT  = 4'd0,
    ACT_INS_BACK   = 4'd1,
    ACT_INS_AT     = 4'd2,
    ACT_INS_BEFORE = 4'd3,
    ACT_INS_AFTER  = 4'd4,
    ACT_DEL_FRONT  = 4'd5,
    ACT_DEL_BACK   = 4'd6,
    ACT_DEL_AT     = 4'd7,
    ACT_DEL_BEFORE = 4'd8,
    ACT_DEL_AFTER  = 4'd9,
    ACT_DEL_MATCH  = 4'd10,
    ACT_SEARCH     = 4'd11,
    ACT_CLEAR      = 4'd12
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_FULL      = 3'd4,
    ST_AT_HEAD   = 3'd5
  } status_e;

  // field write enables of one node entry
  typedef struct packed {
    logic val;
    logic nxt;
    logic prv;
  } node_we_t;

endpackage

// ----- hw/rtl/dll_in_if.sv -----
// Command channel of the doubly linked list engine.
// Depends on dll_pkg.
interface dll_in_if;
  import dll_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [DATA_W-1:0]   data_value;
  logic signed [DATA_W-1:0]   match_value;
  logic [POS_W-1:0]           position;

  modport source (output valid, action, data_value, match_value, position, input ready);
  modport sink   (input valid, action, data_value, match_value, position, output ready);
endinterface

// ----- hw/rtl/dll_out_if.sv -----
// Result channel of the doubly linked list engine.
// Depends on dll_pkg.
interface dll_out_if;
  import dll_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   removed_value;
  logic [CNT_W-1:0]           first_match_index;
  logic [CNT_W-1:0]           match_count;
  logic [CNT_W-1:0]           list_size;

  modport source (output valid, status, removed_value, first_match_index, match_count,
                  list_size, input ready);
  modport sink   (input valid, status, removed_value, first_match_index, match_count,
                  list_size, output ready);
endinterface

// ----- hw/rtl/dll_node_mem.sv -----
// Node memory: value, next link and prev link of every slot.
// One write port with field enables, one registered read port. Depends on dll_pkg.
module dll_node_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned VW    = 32,
  parameter int unsigned LW    = 7,
  parameter int unsigned IW    = 6
) (
  input  logic                 clk_i,
  input  dll_pkg::node_we_t    we_i,
  input  logic [IW-1:0]        wr_addr_i,
  input  logic [VW-1:0]        wr_val_i,
  input  logic [LW-1:0]        wr_nxt_i,
  input  logic [LW-1:0]        wr_prv_i,
  input  logic                 rd_en_i,
  input  logic [IW-1:0]        rd_addr_i,
  output logic [VW-1:0]        rd_val_o,
  output logic [LW-1:0]        rd_nxt_o,
  output logic [LW-1:0]        rd_prv_o
);
  import dll_pkg::*;

  logic [VW-1:0] val_mem [DEPTH];
  logic [LW-1:0] nxt_mem [DEPTH];
  logic [LW-1:0] prv_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.val) val_mem[wr_addr_i] <= wr_val_i;
    if (we_i.nxt) nxt_mem[wr_addr_i] <= wr_nxt_i;
    if (we_i.prv) prv_mem[wr_addr_i] <= wr_prv_i;
    if (rd_en_i) begin
      rd_val_o <= val_mem[rd_addr_i];
      rd_nxt_o <= nxt_mem[rd_addr_i];
      rd_prv_o <= prv_mem[rd_addr_i];
    end
  end

endmodule

// ----- hw/rtl/dll_free_stack.sv -----
// Free-slot stack memory with per-entry valid bits.
// An entry not written since reset or clear reads as its own index. Depends on dll_pkg.
module dll_free_stack #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          push_i,
  input  logic [IW-1:0] push_addr_i,
  input  logic [IW-1:0] push_slot_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [IW-1:0] free_slot_o
);
  import dll_pkg::*;

  logic [IW-1:0]    stk_mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [IW-1:0]    rd_q;
  logic [IW-1:0]    ra_q;
  logic             rdv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rdv_q <= 1'b0;
      ra_q  <= '0;
    end else begin
      rdv_q <= vld_q[rd_addr_i];
      ra_q  <= rd_addr_i;
      if (clear_i) vld_q <= '0;
      else if (push_i) vld_q[push_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) stk_mem[push_addr_i] <= push_slot_i;
    rd_q <= stk_mem[rd_addr_i];
  end

  assign free_slot_o = rdv_q ? rd_q : ra_q;

endmodule

// ----- hw/rtl/doubly_linked_list_engine.sv -----
// Doubly linked list engine, top level: command sequencer, list registers, result register.
// Depends on dll_pkg, dll_in_if, dll_out_if, dll_node_mem, dll_free_stack.
//
//  channel | dir | payload
//  in_i    | in  | action, data_value, match_value, position
//  out_o   | out | status, removed_value, first_match_index, match_count, list_size
//
// One command at a time; ready is high while the sequencer is idle.
// Inserts write the node, then its neighbour links; deletes read the node, then unlink it.
// Position and match commands walk the list through the node memory read port,
// one node per cycle.
// Reset empties the list at once. A result waiting on out_o stalls only the finish step.
module doubly_linked_list_engine #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dll_in_if.sink       in_i,
  dll_out_if.source    out_o
);
  import dll_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned PW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WALK = 9'b000000010,
    S_RD   = 9'b000000100,
    S_LNK0 = 9'b000001000,
    S_LNK1 = 9'b000010000,
    S_LNK2 = 9'b000100000,
    S_UNL0 = 9'b001000000,
    S_UNL1 = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [ACTION_W-1:0]   act_q, act_d;
  logic [VW-1:0]         dat_q, dat_d;
  logic [VW-1:0]         mat_q, mat_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [LW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [LW-1:0]         cnt_q, cnt_d, ft_q, ft_d;
  logic [LW-1:0]         cur_q, cur_d, idx_q, idx_d;
  logic [LW-1:0]         fi_q, fi_d, mc_q, mc_d;
  logic [LW-1:0]         lp_q, lp_d, ln_q, ln_d, u_q, u_d;
  logic [VW-1:0]         v_q, v_d, rem_q, rem_d;
  logic [IW-1:0]         f_q, f_d;
  status_e               sts_q, sts_d;

  logic                  ov_q, ov_d;
  logic [STATUS_W-1:0]   o_sts_q, o_sts_d;
  logic signed [DATA_W-1:0] o_rem_q, o_rem_d;
  logic [CNT_W-1:0]      o_fi_q, o_fi_d, o_mc_q, o_mc_d, o_cnt_q, o_cnt_d;

  node_we_t              nm_we;
  logic [IW-1:0]         nm_wa, nm_ra;
  logic [VW-1:0]         nm_wval, nm_val;
  logic [LW-1:0]         nm_wnxt, nm_wprv, nm_nxt, nm_prv;
  logic                  nm_re;

  logic                  fs_clear, fs_push;
  logic [IW-1:0]         fs_slot;

  logic                  in_acc;
  logic [PW-1:0]         pw, cw, iw_pos, iw_idx;
  logic                  hit, last;
  logic [LW-1:0]         nmc;

  dll_node_mem #(.DEPTH(CAPACITY), .VW(VW), .LW(LW), .IW(IW)) u_node_mem (
    .clk_i     (clk_i),
    .we_i      (nm_we),
    .wr_addr_i (nm_wa),
    .wr_val_i  (nm_wval),
    .wr_nxt_i  (nm_wnxt),
    .wr_prv_i  (nm_wprv),
    .rd_en_i   (nm_re),
    .rd_addr_i (nm_ra),
    .rd_val_o  (nm_val),
    .rd_nxt_o  (nm_nxt),
    .rd_prv_o  (nm_prv)
  );

  dll_free_stack #(.DEPTH(CAPACITY), .IW(IW)) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (fs_clear),
    .push_i      (fs_push),
    .push_addr_i (ft_q[IW-1:0]),
    .push_slot_i (u_q[IW-1:0]),
    .rd_addr_i   (IW'(ft_q - LW'(1))),
    .free_slot_o (fs_slot)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid             = ov_q;
  assign out_o.status            = o_sts_q;
  assign out_o.removed_value     = o_rem_q;
  assign out_o.first_match_index = o_fi_q;
  assign out_o.match_count       = o_mc_q;
  assign out_o.list_size         = o_cnt_q;

  assign pw     = PW'(in_i.position);
  assign cw     = PW'(cnt_q);
  assign iw_pos = PW'(pos_q);
  assign iw_idx = PW'(idx_q);
  assign hit    = (nm_val == mat_q);
  assign last   = (idx_q == cnt_q);
  assign nmc    = mc_q + LW'(hit);

  always_comb begin
    state_d = state_q;
    act_d = act_q; dat_d = dat_q; mat_d = mat_q; pos_d = pos_q;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q; ft_d = ft_q;
    cur_d = cur_q; idx_d = idx_q; fi_d = fi_q; mc_d = mc_q;
    lp_d = lp_q; ln_d = ln_q; u_d = u_q; v_d = v_q; rem_d = rem_q;
    f_d = f_q; sts_d = sts_q;
    ov_d = ov_q && !out_o.ready;
    o_sts_d = o_sts_q; o_rem_d = o_rem_q; o_fi_d = o_fi_q; o_mc_d = o_mc_q;
    o_cnt_d = o_cnt_q;
    nm_we = '0; nm_wa = '0; nm_wval = dat_q; nm_wnxt = ln_q; nm_wprv = lp_q;
    nm_re = 1'b0; nm_ra = '0;
    fs_clear = 1'b0; fs_push = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          act_d = in_i.action;
          dat_d = VW'(in_i.data_value);
          mat_d = VW'(in_i.match_value);
          pos_d = in_i.position;
          sts_d = ST_OK;
          rem_d = '0;
          fi_d  = '0;
          mc_d  = '0;
          idx_d = LW'(1);
          cur_d = head_q;
          state_d = S_DONE;
          if (in_i.action <= ACT_INS_AFTER && cnt_q == NIL) begin
            sts_d = ST_FULL;
          end else begin
            unique case (in_i.action) inside
              ACT_INS_FRONT: begin
                lp_d = NIL; ln_d = head_q; state_d = S_LNK0;
              end
              ACT_INS_BACK: begin
                lp_d = tail_q; ln_d = NIL; state_d = S_LNK0;
              end
              ACT_INS_AT: begin
                if (pw == PW'(1)) begin
                  lp_d = NIL; ln_d = head_q; state_d = S_LNK0;
                end else if (pw == cw + PW'(1)) begin
                  lp_d = tail_q; ln_d = NIL; state_d = S_LNK0;
                end else if (pw > PW'(1) && pw <= cw) begin
                  nm_re = 1'b1; nm_ra = head_q[IW-1:0]; state_d = S_WALK;
                end else begin
                  sts_d = ST_BAD_INDEX;
                end
              end
              ACT_INS_BEFORE, ACT_INS_AFTER, ACT_DEL_BEFORE, ACT_DEL_AFTER,
              ACT_DEL_MATCH: begin
                if (cnt_q == '0) begin
                  sts_d = ST_EMPTY;
                end else begin
                  nm_re = 1'b1; nm_ra = head_q[IW-1:0]; state_d = S_WALK;
                end
              end
              ACT_DEL_FRONT, ACT_DEL_BACK: begin
                if (cnt_q == '0) begin
                  sts_d = ST_EMPTY;
                end else begin
                  u_d = (in_i.action == ACT_DEL_FRONT) ? head_q : tail_q;
                  nm_re = 1'b1; nm_ra = u_d[IW-1:0]; state_d = S_RD;
                end
              end
              ACT_DEL_AT: begin
                if (pw == PW'(1) || pw == cw) begin
                  if (cnt_q == '0) begin
                    sts_d = ST_EMPTY;
                  end else begin
                    u_d = (pw == PW'(1)) ? head_q : tail_q;
                    nm_re = 1'b1; nm_ra = u_d[IW-1:0]; state_d = S_RD;
                  end
                end else if (pw > PW'(1) && pw < cw) begin
                  nm_re = 1'b1; nm_ra = head_q[IW-1:0]; state_d = S_WALK;
                end else begin
                  sts_d = ST_BAD_INDEX;
                end
              end
              ACT_SEARCH: begin
                if (cnt_q == '0) begin
                  sts_d = ST_NOT_FOUND;
                end else begin
                  nm_re = 1'b1; nm_ra = head_q[IW-1:0]; state_d = S_WALK;
                end
              end
              ACT_CLEAR: begin
                fs_clear = 1'b1;
                head_d = NIL; tail_d = NIL; cnt_d = '0; ft_d = NIL;
              end
              default: ;
            endcase
          end
        end
      end

      S_WALK: begin
        // node memory output holds slot cur_q, node number idx_q
        state_d = S_DONE;
        case (act_q)
          ACT_INS_AT, ACT_DEL_AT: begin
            if (iw_idx == iw_pos) begin
              lp_d = nm_prv;
              u_d  = cur_q;
              v_d  = nm_val;
              if (act_q == ACT_INS_AT) begin
                ln_d = cur_q; state_d = S_LNK0;
              end else begin
                ln_d = nm_nxt; state_d = S_UNL0;
              end
            end else begin
              state_d = S_WALK;
            end
          end
          ACT_SEARCH: begin
            mc_d = nmc;
            if (hit && mc_q == '0) fi_d = idx_q;
            if (last) begin
              sts_d = (nmc == '0) ? ST_NOT_FOUND : ST_OK;
            end else begin
              state_d = S_WALK;
            end
          end
          default: begin
            if (hit) begin
              case (act_q)
                ACT_INS_BEFORE: begin
                  lp_d = nm_prv; ln_d = cur_q; state_d = S_LNK0;
                end
                ACT_INS_AFTER: begin
                  lp_d = cur_q; ln_d = nm_nxt; state_d = S_LNK0;
                end
                ACT_DEL_BEFORE: begin
                  if (cur_q == head_q) begin
                    sts_d = ST_AT_HEAD;
                  end else begin
                    u_d = nm_prv; nm_re = 1'b1; nm_ra = nm_prv[IW-1:0]; state_d = S_RD;
                  end
                end
                ACT_DEL_AFTER: begin
                  if (nm_nxt == NIL) begin
                    sts_d = ST_NOT_FOUND;
                  end else begin
                    u_d = nm_nxt; nm_re = 1'b1; nm_ra = nm_nxt[IW-1:0]; state_d = S_RD;
                  end
                end
                default: begin
                  u_d = cur_q; lp_d = nm_prv; ln_d = nm_nxt; v_d = nm_val;
                  state_d = S_UNL0;
                end
              endcase
            end else if (last) begin
              sts_d = ST_NOT_FOUND;
            end else begin
              state_d = S_WALK;
            end
          end
        endcase
        if (state_d == S_WALK) begin
          cur_d = nm_nxt;
          idx_d = idx_q + LW'(1);
          nm_re = 1'b1;
          nm_ra = nm_nxt[IW-1:0];
        end
      end

      S_RD: begin
        lp_d = nm_prv; ln_d = nm_nxt; v_d = nm_val;
        state_d = S_UNL0;
      end

      S_LNK0: begin
        f_d = fs_slot;
        nm_we = '{val: 1'b1, nxt: 1'b1, prv: 1'b1};
        nm_wa = fs_slot;
        if (lp_q == NIL) head_d = LW'(fs_slot);
        if (ln_q == NIL) tail_d = LW'(fs_slot);
        cnt_d = cnt_q + LW'(1);
        ft_d  = ft_q - LW'(1);
        state_d = S_LNK1;
      end

      S_LNK1: begin
        if (lp_q != NIL) begin
          nm_we.nxt = 1'b1; nm_wa = lp_q[IW-1:0]; nm_wnxt = LW'(f_q);
        end
        state_d = S_LNK2;
      end

      S_LNK2: begin
        if (ln_q != NIL) begin
          nm_we.prv = 1'b1; nm_wa = ln_q[IW-1:0]; nm_wprv = LW'(f_q);
        end
        state_d = S_DONE;
      end

      S_UNL0: begin
        if (lp_q != NIL) begin
          nm_we.nxt = 1'b1; nm_wa = lp_q[IW-1:0]; nm_wnxt = ln_q;
        end
        if (lp_q == NIL) head_d = ln_q;
        if (ln_q == NIL) tail_d = lp_q;
        if (cnt_q == LW'(1)) begin
          head_d = NIL; tail_d = NIL;
        end
        cnt_d   = cnt_q - LW'(1);
        fs_push = 1'b1;
        ft_d    = ft_q + LW'(1);
        rem_d   = v_q;
        state_d = S_UNL1;
      end

      S_UNL1: begin
        if (ln_q != NIL) begin
          nm_we.prv = 1'b1; nm_wa = ln_q[IW-1:0]; nm_wprv = lp_q;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          o_sts_d = sts_q;
          o_rem_d = DATA_W'(signed'(rem_q));
          o_fi_d  = CNT_W'(fi_q);
          o_mc_d  = CNT_W'(mc_q);
          o_cnt_d = CNT_W'(cnt_q);
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NIL;
      tail_q  <= NIL;
      cnt_q   <= '0;
      ft_q    <= NIL;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      ft_q    <= ft_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; dat_q <= dat_d; mat_q <= mat_d; pos_q <= pos_d;
    cur_q <= cur_d; idx_q <= idx_d; fi_q <= fi_d; mc_q <= mc_d;
    lp_q <= lp_d; ln_q <= ln_d; u_q <= u_d; v_q <= v_d; rem_q <= rem_d;
    f_q <= f_d; sts_q <= sts_d;
    o_sts_q <= o_sts_d; o_rem_q <= o_rem_d; o_fi_q <= o_fi_d;
    o_mc_q <= o_mc_d; o_cnt_q <= o_cnt_d;
  end

  a_slots_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW'(cnt_q) + PW'(ft_q)) == PW'(CAPACITY))
    else $error("node count and free stack depth disagree");

  a_empty_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == NIL && tail_q == NIL))
    else $error("empty list with live head or tail");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("sequencer idle right after accepting an item");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && ov_q && !out_o.ready) |=> (state_q == S_DONE))
    else $error("result finished over a pending item");

endmodule
